[hw/rtl/stpa_pkg.sv]
package stpa_pkg;

    localparam int DEFAULT_LEAVES = 1024;

    localparam int INDEX_W = 10;
    localparam int WEIGHT_W = 32;
    localparam int BOUND_W = 11;
    localparam int SUM_W = 64;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [SUM_W-1:0] sum_t;

endpackage

[hw/rtl/segment_tree_point_add_range_sum.sv]
// channel   signals                                          handshake
// command   start, busy, kind, index, weight,                word taken when start & !busy
//           range_low, range_high
// result    done, range_sum                                  word valid while done is high
//
// after reset the node memory is cleared one node a cycle, with busy high throughout
// an update runs on the shared 64-bit adder: leaf read, leaf write, then one parent write
// per level up to the root; an index past the last leaf is dropped at accept
// a query walks each level in a low-bound slot and a high-bound slot, then a final bound
// test and a state that presents the sum
// done is high for exactly one cycle; the receiver cannot stall
module segment_tree_point_add_range_sum #(
    parameter int LEAVES = stpa_pkg::DEFAULT_LEAVES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  kind,
    input  logic [stpa_pkg::INDEX_W-1:0]          index,
    input  logic signed [stpa_pkg::WEIGHT_W-1:0]  weight,
    input  logic [stpa_pkg::BOUND_W-1:0]          range_low,
    input  logic [stpa_pkg::BOUND_W-1:0]          range_high,
    output logic                                  done,
    output logic signed [stpa_pkg::SUM_W-1:0]     range_sum
);

    // node address and walk pointer widths (pointer must hold 2*LEAVES)
    localparam int NODES = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam int WEIGHT_W_L = stpa_pkg::WEIGHT_W;

    // sequencer states
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_LEAF_RD = 3'd2;
    localparam logic [2:0] S_LEAF_WR = 3'd3;
    localparam logic [2:0] S_UP      = 3'd4;
    localparam logic [2:0] S_WALK    = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // node memory: one write port, one registered read port
    stpa_pkg::sum_t mem [NODES];
    stpa_pkg::sum_t rdata_reg;
    logic              we;
    logic [NODE_W-1:0] waddr;
    stpa_pkg::sum_t    wdata;
    logic              rd_en;
    logic [NODE_W-1:0] raddr;

    logic [2:0] state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [WEIGHT_W_L-1:0] weight_reg, weight_next;
    stpa_pkg::sum_t acc_reg, acc_next;
    logic [PTR_W-1:0] lo_reg, lo_next;
    logic [PTR_W-1:0] hi_reg, hi_next;
    logic pend_reg, pend_next;
    logic phase_reg, phase_next;
    logic done_reg, done_next;
    stpa_pkg::sum_t range_sum_reg, range_sum_next;

    // shared adder and its operand select
    stpa_pkg::sum_t add_b;
    stpa_pkg::sum_t sum;

    // helpers for the walk
    logic [NODE_W-1:0] parent;
    logic [31:0]       low_ext;
    logic [31:0]       high_ext;
    logic [PTR_W-1:0]  low_clamp;
    logic [PTR_W-1:0]  high_clamp;
    logic              accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign range_sum = range_sum_reg;

    assign add_b = (state_reg == S_LEAF_WR)
                 ? {{(stpa_pkg::SUM_W - WEIGHT_W_L){weight_reg[WEIGHT_W_L-1]}}, weight_reg}
                 : acc_reg;
    assign sum = rdata_reg + add_b;

    assign parent = {1'b0, node_reg[NODE_W-1:1]};

    // bounds past the end are clamped to the end
    assign low_ext = {{(32 - stpa_pkg::BOUND_W){1'b0}}, range_low};
    assign high_ext = {{(32 - stpa_pkg::BOUND_W){1'b0}}, range_high};
    assign low_clamp = (low_ext > 32'(LEAVES)) ? PTR_W'(LEAVES) : PTR_W'(low_ext);
    assign high_clamp = (high_ext > 32'(LEAVES)) ? PTR_W'(LEAVES) : PTR_W'(high_ext);

    always_comb
    begin
        state_next = state_reg;
        node_next = node_reg;
        weight_next = weight_reg;
        acc_next = acc_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        pend_next = pend_reg;
        phase_next = phase_reg;
        done_next = 1'b0;
        range_sum_next = range_sum_reg;
        we = 1'b0;
        waddr = node_reg;
        wdata = sum;
        rd_en = 1'b0;
        raddr = node_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = node_reg;
                wdata = '0;
                node_next = node_reg + NODE_W'(1);
                if (node_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == stpa_pkg::KIND_ADD)
                    begin
                        // out-of-range leaf: drop the word
                        if ({{(32 - stpa_pkg::INDEX_W){1'b0}}, index} < 32'(LEAVES))
                        begin
                            node_next = NODE_W'({{(32 - stpa_pkg::INDEX_W){1'b0}}, index}
                                                + 32'(LEAVES));
                            weight_next = weight;
                            state_next = S_LEAF_RD;
                        end
                    end
                    else
                    begin
                        lo_next = low_clamp + PTR_W'(LEAVES);
                        hi_next = high_clamp + PTR_W'(LEAVES);
                        acc_next = '0;
                        pend_next = 1'b0;
                        phase_next = 1'b0;
                        state_next = S_WALK;
                    end
                end
            end
            S_LEAF_RD:
            begin
                rd_en = 1'b1;
                raddr = node_reg;
                state_next = S_LEAF_WR;
            end
            S_LEAF_WR:
            begin
                // leaf += weight, then fetch its sibling
                we = 1'b1;
                waddr = node_reg;
                wdata = sum;
                acc_next = sum;
                rd_en = 1'b1;
                raddr = {node_reg[NODE_W-1:1], ~node_reg[0]};
                state_next = S_UP;
            end
            S_UP:
            begin
                // parent = node + sibling
                we = 1'b1;
                waddr = parent;
                wdata = sum;
                acc_next = sum;
                node_next = parent;
                if (parent == NODE_W'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en = 1'b1;
                    raddr = {parent[NODE_W-1:1], ~parent[0]};
                end
            end
            S_WALK:
            begin
                // fold in the node read last cycle
                if (pend_reg)
                begin
                    acc_next = sum;
                end
                if (!phase_reg)
                begin
                    // low bound slot, also the loop test
                    if (lo_reg >= hi_reg)
                    begin
                        pend_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (lo_reg[0])
                    begin
                        rd_en = 1'b1;
                        raddr = lo_reg[NODE_W-1:0];
                        pend_next = 1'b1;
                        lo_next = lo_reg + PTR_W'(1);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    // high bound slot, then both bounds move up a level
                    if (hi_reg[0])
                    begin
                        rd_en = 1'b1;
                        raddr = {hi_reg[NODE_W-1:1], 1'b0};
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                    lo_next = lo_reg >> 1;
                    hi_next = hi_reg >> 1;
                    phase_next = 1'b0;
                end
            end
            S_DONE:
            begin
                range_sum_next = acc_reg;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_reg <= '0;
            pend_reg <= 1'b0;
            phase_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg <= node_next;
            pend_reg <= pend_next;
            phase_reg <= phase_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        acc_reg <= acc_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        range_sum_reg <= range_sum_next;
    end

    // node memory ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule
